// ===== hdl/pid_controller_step_unit_defines.svh =====
// Assertion macros used by the controller step unit.
`ifndef PID_CONTROLLER_STEP_UNIT_DEFINES_SVH
`define PID_CONTROLLER_STEP_UNIT_DEFINES_SVH

`ifndef SYNTH
`define PCS_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	prop) else $error("pid step unit check failed");
`define PCS_ASSERT_ALWAYS(lbl, prop) lbl: assert property (@(posedge clk) prop) \
	else $error("pid step unit check failed");
`else
`define PCS_ASSERT(lbl, prop)
`define PCS_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== hdl/pcs_pkg.sv =====
package pcs_pkg;

	localparam int DATA_W    = 32;
	localparam int GAIN_W    = 32;
	localparam int TIME_W    = 32;
	localparam int PERIOD_W  = 16;
	localparam int MAG_W     = 31;
	localparam int COUNT_W   = 16;
	localparam int CFG_IDX_W = 3;

	localparam int DEFAULT_LIMIT_INT = 100;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SEPARATION = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ICLAMP     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW     = 3'd7;

	typedef struct packed {
		logic start;
		logic op_div;
		logic neg;
	} pcs_ctl_t;

endpackage

// ===== hdl/pcs_ifs.sv =====
interface pcs_sample_if;
	import pcs_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [DATA_W-1:0]  measured;
	logic signed [DATA_W-1:0]  setpoint;
	logic        [TIME_W-1:0]  time_stamp;
	modport source (output valid, measured, setpoint, time_stamp, input ready);
	modport sink (input valid, measured, setpoint, time_stamp, output ready);
endinterface

interface pcs_result_if;
	import pcs_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [DATA_W-1:0]  drive;
	logic                      fresh;
	modport source (output valid, drive, fresh, input ready);
	modport sink (input valid, drive, fresh, output ready);
endinterface

interface pcs_cfg_if;
	import pcs_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [DATA_W-1:0]     data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/pcs_shift_unit.sv =====
module pcs_shift_unit #(
	parameter int AW = 48
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  pcs_pkg::pcs_ctl_t                ctl,
	input  logic [AW-1:0]                    a_mag,
	input  logic [pcs_pkg::GAIN_W-1:0]       b_mag,
	output logic                             done,
	output logic signed [AW+pcs_pkg::GAIN_W:0] result
);
	import pcs_pkg::*;

	localparam int PW = AW + GAIN_W;
	localparam int CW = $clog2(AW + 1);

	logic              busy_q, fin_q, done_q;
	logic [CW-1:0]     cnt_q;
	logic              div_q, neg_q;
	logic [PW-1:0]     p_q;
	logic [AW-1:0]     a_q;
	logic [GAIN_W-1:0] b_q, rem_q;
	logic signed [PW:0] res_q;

	logic [AW:0]   x, y, s;
	logic          fits;
	logic [PW-1:0] mag;

	// One adder serves both: add for shift-and-add multiply, subtract for
	// restoring division.
	assign x = div_q ? {{(AW-GAIN_W){1'b0}}, rem_q, a_q[AW-1]} : {1'b0, p_q[PW-1:GAIN_W]};
	assign y = div_q ? {{(AW+1-GAIN_W){1'b0}}, b_q} : {1'b0, a_q};
	assign s = div_q ? (x - y) : (x + y);
	assign fits = !s[AW];
	assign mag = div_q ? {{(PW-AW){1'b0}}, a_q} : p_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q && !busy_q && !ctl.start;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ctl.op_div ? CW'(AW) : CW'(GAIN_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			div_q <= ctl.op_div;
			neg_q <= ctl.neg;
			a_q   <= a_mag;
			b_q   <= b_mag;
			rem_q <= '0;
			p_q   <= {{AW{1'b0}}, b_mag};
		end else if (busy_q) begin
			if (div_q) begin
				a_q   <= {a_q[AW-2:0], fits};
				rem_q <= fits ? s[GAIN_W-1:0] : x[GAIN_W-1:0];
			end else begin
				p_q <= p_q[0] ? {s, p_q[GAIN_W-1:1]} : {1'b0, p_q[PW-1:1]};
			end
		end else if (fin_q) begin
			res_q <= neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

// ===== hdl/pid_controller_step_unit.sv =====
// Channel  | Dir | Word carried
// ---------+-----+--------------------------------------------
// sample   | in  | measured, setpoint, time_stamp
// result   | out | drive, fresh
// cfg      | in  | index, data (register write, always ready)
//
// A held update (less than one sample period elapsed) goes straight to the output.
// A fresh update runs its multiplies and divides, more of them when the integral
// decays, on the shared shift-add/restoring-divide unit.
// The sample channel is ready only between items; a finished word waits in
// the output register while the next item is taken.
// Reset clears the controller history and loads register defaults.
`include "pid_controller_step_unit_defines.svh"

module pid_controller_step_unit #(
	parameter int FRAC_BITS = 16,
	parameter int ACC_WIDTH = 48
) (
	input logic          clk,
	input logic          arst_n,
	pcs_sample_if.sink   sample,
	pcs_result_if.source result,
	pcs_cfg_if.sink      cfg
);
	import pcs_pkg::*;

	localparam int AW = (ACC_WIDTH > 48) ? ACC_WIDTH : 48;
	localparam int PW = AW + GAIN_W;
	localparam int SW = DATA_W + 2;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_PREP   = 4'd1;
	localparam logic [3:0] S_CHK    = 4'd2;
	localparam logic [3:0] S_INT    = 4'd3;
	localparam logic [3:0] S_IDIV   = 4'd4;
	localparam logic [3:0] S_IMUL   = 4'd5;
	localparam logic [3:0] S_IADD   = 4'd6;
	localparam logic [3:0] S_ICLAMP = 4'd7;
	localparam logic [3:0] S_DMUL   = 4'd8;
	localparam logic [3:0] S_DDIV   = 4'd9;
	localparam logic [3:0] S_PTERM  = 4'd10;
	localparam logic [3:0] S_ITERM  = 4'd11;
	localparam logic [3:0] S_DTERM  = 4'd12;
	localparam logic [3:0] S_SUM    = 4'd13;
	localparam logic [3:0] S_OUT    = 4'd14;

	localparam logic signed [DATA_W-1:0] I32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] I32_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
	localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

	// Configuration registers.
	logic signed [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
	logic [PERIOD_W-1:0]      period_q;
	logic [MAG_W-1:0]         limit_q, sep_q, iclamp_q;
	logic [COUNT_W-1:0]       window_q;

	// Controller history.
	logic signed [DATA_W-1:0]    prev_setpoint_q, prev_error_q, prev_drive_q;
	logic [TIME_W-1:0]           prev_time_q;
	logic signed [ACC_WIDTH-1:0] acc_q;
	logic [COUNT_W-1:0]          samples_q;

	// Working registers for one item.
	logic [3:0]               state_q;
	logic                     started_q;
	logic signed [DATA_W-1:0] meas_q, target_q, err_q, drive_res_q;
	logic [TIME_W-1:0]        now_q, elapsed_q;
	logic signed [DATA_W:0]   diff_q, deriv_q;
	logic signed [PW:0]       tmp_q;
	logic signed [SW-1:0]     sum_q;
	logic                     fresh_res_q;
	logic                     out_valid_q, out_fresh_q;
	logic signed [DATA_W-1:0] out_drive_q;

	// Shared unit hookup.
	pcs_ctl_t           eng_ctl;
	logic               eng_state, eng_done;
	logic [AW-1:0]      eng_a;
	logic [GAIN_W-1:0]  eng_b;
	logic signed [PW:0] eng_res;

	logic [PERIOD_W-1:0]         period_eff;
	logic signed [DATA_W:0]      sp_diff;
	logic signed [DATA_W-1:0]    err_sat;
	logic                        chg;
	logic [DATA_W:0]             err_abs;
	logic signed [ACC_WIDTH:0]   add_lhs, add_sum, iclamp_ext, acc_ext;
	logic signed [ACC_WIDTH-1:0] add_sat, acc_clamped;
	logic [ACC_WIDTH:0]          acc_mag;
	logic signed [DATA_W-1:0]    iop;
	logic [DATA_W-1:0]           iop_mag, gp_mag, gi_mag, gd_mag;
	logic [DATA_W:0]             diff_mag, deriv_mag;
	logic [PW:0]                 tmp_mag;
	logic signed [PW:0]          shifted;
	logic signed [DATA_W-1:0]    term32;
	logic signed [SW-1:0]        lim_ext, drive_clamped;
	logic                        acc_ok;

	assign period_eff = (period_q == '0) ? PERIOD_W'(1) : period_q;
	assign chg = (target_q != prev_setpoint_q);

	assign sp_diff = {target_q[DATA_W-1], target_q} - {meas_q[DATA_W-1], meas_q};
	always_comb begin
		if (sp_diff[DATA_W] != sp_diff[DATA_W-1]) begin
			err_sat = sp_diff[DATA_W] ? I32_MIN : I32_MAX;
		end else begin
			err_sat = sp_diff[DATA_W-1:0];
		end
	end

	assign err_abs = err_q[DATA_W-1] ? -{err_q[DATA_W-1], err_q} : {1'b0, err_q};

	// The integral adder serves both the windowed sum and the decay step.
	assign add_lhs = (state_q == S_IADD) ? tmp_q[ACC_WIDTH:0] : {acc_q[ACC_WIDTH-1], acc_q};
	assign add_sum = add_lhs + {{(ACC_WIDTH+1-DATA_W){err_q[DATA_W-1]}}, err_q};
	always_comb begin
		if (add_sum[ACC_WIDTH] != add_sum[ACC_WIDTH-1]) begin
			add_sat = add_sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
		end else begin
			add_sat = add_sum[ACC_WIDTH-1:0];
		end
	end

	assign acc_ext    = {acc_q[ACC_WIDTH-1], acc_q};
	assign iclamp_ext = {{(ACC_WIDTH+1-MAG_W){1'b0}}, iclamp_q};
	assign acc_ok     = !(acc_ext > iclamp_ext) && !(acc_ext < -iclamp_ext);
	always_comb begin
		if (acc_ext > iclamp_ext) begin
			acc_clamped = iclamp_ext[ACC_WIDTH-1:0];
		end else if (acc_ext < -iclamp_ext) begin
			acc_clamped = ACC_WIDTH'(-iclamp_ext);
		end else begin
			acc_clamped = acc_q;
		end
	end
	assign acc_mag = acc_q[ACC_WIDTH-1] ? -acc_ext : acc_ext;

	always_comb begin
		if (acc_q[ACC_WIDTH-1:DATA_W-1] == {(ACC_WIDTH-DATA_W+1){acc_q[DATA_W-1]}}) begin
			iop = acc_q[DATA_W-1:0];
		end else begin
			iop = acc_q[ACC_WIDTH-1] ? I32_MIN : I32_MAX;
		end
	end

	assign iop_mag   = iop[DATA_W-1] ? -iop : iop;
	assign gp_mag    = gain_p_q[GAIN_W-1] ? -gain_p_q : gain_p_q;
	assign gi_mag    = gain_i_q[GAIN_W-1] ? -gain_i_q : gain_i_q;
	assign gd_mag    = gain_d_q[GAIN_W-1] ? -gain_d_q : gain_d_q;
	assign diff_mag  = diff_q[DATA_W] ? -diff_q : diff_q;
	assign deriv_mag = deriv_q[DATA_W] ? -deriv_q : deriv_q;
	assign tmp_mag   = tmp_q[PW] ? -tmp_q : tmp_q;

	always_comb begin
		eng_state   = 1'b1;
		eng_ctl.op_div = 1'b0;
		eng_ctl.neg = 1'b0;
		eng_a       = '0;
		eng_b       = '0;
		unique case (state_q)
			S_IDIV: begin
				eng_ctl.op_div = 1'b1;
				eng_a = AW'(acc_mag);
				eng_b = {{(GAIN_W-COUNT_W){1'b0}}, samples_q};
				eng_ctl.neg = acc_q[ACC_WIDTH-1];
			end
			S_IMUL: begin
				eng_a = tmp_mag[AW-1:0];
				eng_b = {{(GAIN_W-COUNT_W){1'b0}}, samples_q - 1'b1};
				eng_ctl.neg = tmp_q[PW];
			end
			S_DMUL: begin
				eng_a = {{(AW-DATA_W-1){1'b0}}, diff_mag};
				eng_b = {{(GAIN_W-PERIOD_W){1'b0}}, period_eff};
				eng_ctl.neg = diff_q[DATA_W];
			end
			S_DDIV: begin
				eng_ctl.op_div = 1'b1;
				eng_a = tmp_mag[AW-1:0];
				eng_b = elapsed_q;
				eng_ctl.neg = tmp_q[PW];
			end
			S_PTERM: begin
				eng_a = {{(AW-DATA_W){1'b0}}, err_abs[DATA_W-1:0]};
				eng_b = gp_mag;
				eng_ctl.neg = err_q[DATA_W-1] ^ gain_p_q[GAIN_W-1];
			end
			S_ITERM: begin
				eng_a = {{(AW-DATA_W){1'b0}}, iop_mag};
				eng_b = gi_mag;
				eng_ctl.neg = iop[DATA_W-1] ^ gain_i_q[GAIN_W-1];
			end
			S_DTERM: begin
				eng_a = {{(AW-DATA_W){1'b0}}, deriv_mag[DATA_W-1:0]};
				eng_b = gd_mag;
				eng_ctl.neg = deriv_q[DATA_W] ^ gain_d_q[GAIN_W-1];
			end
			default: eng_state = 1'b0;
		endcase
		eng_ctl.start = eng_state && !started_q;
	end

	pcs_shift_unit #(.AW(AW)) u_shift (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (eng_ctl),
		.a_mag  (eng_a),
		.b_mag  (eng_b),
		.done   (eng_done),
		.result (eng_res)
	);

	// Product scaled back by the fraction bits, floor rounding, then saturated.
	assign shifted = eng_res >>> FRAC_BITS;
	always_comb begin
		if (shifted[PW:DATA_W-1] == {(PW-DATA_W+2){shifted[DATA_W-1]}}) begin
			term32 = shifted[DATA_W-1:0];
		end else begin
			term32 = shifted[PW] ? I32_MIN : I32_MAX;
		end
	end

	assign lim_ext = {{(SW-MAG_W){1'b0}}, limit_q};
	always_comb begin
		if (sum_q > lim_ext) begin
			drive_clamped = lim_ext;
		end else if (sum_q < -lim_ext) begin
			drive_clamped = -lim_ext;
		end else begin
			drive_clamped = sum_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q        <= '0;
			gain_i_q        <= '0;
			gain_d_q        <= '0;
			period_q        <= PERIOD_W'(1);
			limit_q         <= MAG_W'(DEFAULT_LIMIT_INT << FRAC_BITS);
			sep_q           <= '0;
			iclamp_q        <= '0;
			window_q        <= '0;
			prev_setpoint_q <= '0;
			prev_error_q    <= '0;
			prev_drive_q    <= '0;
			prev_time_q     <= '0;
			acc_q           <= '0;
			samples_q       <= '0;
			state_q         <= S_IDLE;
			started_q       <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					REG_GAIN_P:     gain_p_q <= cfg.data;
					REG_GAIN_I:     gain_i_q <= cfg.data;
					REG_GAIN_D:     gain_d_q <= cfg.data;
					REG_PERIOD:     period_q <= cfg.data[PERIOD_W-1:0];
					REG_LIMIT:      limit_q  <= cfg.data[MAG_W-1:0];
					REG_SEPARATION: sep_q    <= cfg.data[MAG_W-1:0];
					REG_ICLAMP:     iclamp_q <= cfg.data[MAG_W-1:0];
					REG_WINDOW:     window_q <= cfg.data[COUNT_W-1:0];
					default: ;
				endcase
			end

			// A finished word may replace the one being taken in the same cycle.
			if (state_q == S_OUT && (!out_valid_q || result.ready)) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			if (eng_ctl.start) begin
				started_q <= 1'b1;
			end else if (eng_done) begin
				started_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (sample.valid) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					// A new target clears the integral, error and drive history even if the update is held.
					if (chg) begin
						acc_q        <= '0;
						samples_q    <= '0;
						prev_error_q <= '0;
						prev_drive_q <= '0;
					end
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (elapsed_q < {{(TIME_W-PERIOD_W){1'b0}}, period_eff}) begin
						state_q <= S_OUT;
					end else if (gain_i_q != '0) begin
						state_q <= S_INT;
					end else begin
						state_q <= S_DMUL;
					end
				end
				S_INT: begin
					if (err_abs > {2'b00, sep_q}) begin
						acc_q   <= '0;
						state_q <= S_ICLAMP;
					end else if (samples_q < window_q) begin
						acc_q     <= add_sat;
						samples_q <= samples_q + 1'b1;
						state_q   <= S_ICLAMP;
					end else if (samples_q == '0) begin
						acc_q   <= '0;
						state_q <= S_ICLAMP;
					end else begin
						state_q <= S_IDIV;
					end
				end
				S_IDIV:  if (eng_done) state_q <= S_IMUL;
				S_IMUL:  if (eng_done) state_q <= S_IADD;
				S_IADD: begin
					acc_q   <= add_sat;
					state_q <= S_ICLAMP;
				end
				S_ICLAMP: begin
					acc_q   <= acc_clamped;
					state_q <= S_DMUL;
				end
				S_DMUL:  if (eng_done) state_q <= S_DDIV;
				S_DDIV:  if (eng_done) state_q <= S_PTERM;
				S_PTERM: if (eng_done) state_q <= S_ITERM;
				S_ITERM: if (eng_done) state_q <= S_DTERM;
				S_DTERM: if (eng_done) state_q <= S_SUM;
				S_SUM: begin
					prev_time_q     <= now_q;
					prev_setpoint_q <= target_q;
					prev_error_q    <= err_q;
					prev_drive_q    <= drive_clamped[DATA_W-1:0];
					state_q         <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || result.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q) inside
			S_IDLE: begin
				meas_q   <= sample.measured;
				target_q <= sample.setpoint;
				now_q    <= sample.time_stamp;
			end
			S_PREP: begin
				err_q     <= err_sat;
				elapsed_q <= now_q - prev_time_q;
			end
			S_CHK: begin
				drive_res_q <= prev_drive_q;
				fresh_res_q <= 1'b0;
				diff_q      <= {err_q[DATA_W-1], err_q} - {prev_error_q[DATA_W-1], prev_error_q};
				sum_q       <= '0;
			end
			S_IDIV, S_IMUL, S_DMUL: begin
				if (eng_done) tmp_q <= eng_res;
			end
			S_DDIV: begin
				if (eng_done) deriv_q <= eng_res[DATA_W:0];
			end
			S_PTERM, S_ITERM, S_DTERM: begin
				if (eng_done) sum_q <= sum_q + {{(SW-DATA_W){term32[DATA_W-1]}}, term32};
			end
			S_SUM: begin
				drive_res_q <= drive_clamped[DATA_W-1:0];
				fresh_res_q <= 1'b1;
			end
			S_OUT: begin
				if (!out_valid_q || result.ready) begin
					out_drive_q <= drive_res_q;
					out_fresh_q <= fresh_res_q;
				end
			end
			default: ;
		endcase
	end

	assign sample.ready = (state_q == S_IDLE);
	assign cfg.ready    = 1'b1;
	assign result.valid = out_valid_q;
	assign result.drive = out_drive_q;
	assign result.fresh = out_fresh_q;

	`PCS_ASSERT(a_held_word_is_last_drive, $rose(result.valid) && !result.fresh |-> result.drive == prev_drive_q)
	`PCS_ASSERT(a_fresh_within_limit, result.valid && result.fresh |-> result.drive <= $signed({1'b0, limit_q}) && result.drive >= -$signed({1'b0, limit_q}))
	`PCS_ASSERT(a_integral_clamped, state_q == S_DMUL && gain_i_q != '0 |-> acc_ok)
	`PCS_ASSERT(a_unit_done_in_use, eng_done |-> eng_state && started_q)

endmodule
